// File: src/vspc_pkg.sv
// ============================================================================
// vspc_pkg
// Shared types and constants for the scan-out pixel converter.
// ============================================================================
package vspc_pkg;

  localparam int VRAM_ROW_WORDS = 1024;
  localparam int ROW_BITS       = $clog2(VRAM_ROW_WORDS);
  localparam int INDEX_W        = 19;
  localparam int ADDR_W         = 5;

  localparam logic [2:0] REG_OUTPUT_FORMAT     = 3'd0;
  localparam logic [2:0] REG_TRUE_COLOR_ENABLE = 3'd1;
  localparam logic [2:0] REG_CONTENT_WIDTH     = 3'd2;
  localparam logic [2:0] REG_DISPLAY_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_VERTICAL_OFFSET   = 3'd4;
  localparam logic [2:0] REG_HORIZONTAL_OFFSET = 3'd5;
  localparam logic [2:0] REG_SOURCE_X          = 3'd6;
  localparam logic [2:0] REG_SOURCE_Y          = 3'd7;

  localparam logic [10:0] CONTENT_WIDTH_RST  = 11'd320;
  localparam logic [9:0]  DISPLAY_HEIGHT_RST = 10'd240;

  typedef struct packed {
    logic        output_format;
    logic        true_color_enable;
    logic [10:0] content_width;
    logic [9:0]  display_height;
    logic [8:0]  vertical_offset;
    logic [9:0]  horizontal_offset;
    logic [9:0]  source_x;
    logic [8:0]  source_y;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

endpackage

// File: src/vspc_in_if.sv
// ============================================================================
// vspc_in_if
// Input channel: one output-surface position with its fetched pixels.
// ============================================================================
interface vspc_in_if;
  logic        valid;
  logic        ready;
  logic [8:0]  out_row;
  logic [10:0] out_col;
  logic [15:0] vram_pixel;
  logic [23:0] shadow_pixel;

  modport source (output valid, out_row, out_col, vram_pixel, shadow_pixel, input ready);
  modport sink   (input valid, out_row, out_col, vram_pixel, shadow_pixel, output ready);
endinterface

// File: src/vspc_out_if.sv
// ============================================================================
// vspc_out_if
// Output channel: one converted pixel with its index and shadow write-back.
// ============================================================================
interface vspc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [18:0] source_index;
  logic        is_content;
  logic        shadow_write;
  logic [23:0] shadow_value;

  modport source (output valid, pixel_value, source_index, is_content, shadow_write,
                  shadow_value, input ready);
  modport sink   (input valid, pixel_value, source_index, is_content, shadow_write,
                  shadow_value, output ready);
endinterface

// File: src/vspc_apb_regs.sv
// ============================================================================
// vspc_apb_regs
// APB configuration register file for the scan-out pixel converter.
// ============================================================================
module vspc_apb_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vspc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output vspc_pkg::cfg_t            cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[vspc_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_format     <= 1'b0;
      cfg.true_color_enable <= 1'b0;
      cfg.content_width     <= vspc_pkg::CONTENT_WIDTH_RST;
      cfg.display_height    <= vspc_pkg::DISPLAY_HEIGHT_RST;
      cfg.vertical_offset   <= '0;
      cfg.horizontal_offset <= '0;
      cfg.source_x          <= '0;
      cfg.source_y          <= '0;
    end else if (wr) begin
      unique case (idx)
        vspc_pkg::REG_OUTPUT_FORMAT:     cfg.output_format     <= pwdata[0];
        vspc_pkg::REG_TRUE_COLOR_ENABLE: cfg.true_color_enable <= pwdata[0];
        vspc_pkg::REG_CONTENT_WIDTH:     cfg.content_width     <= pwdata[10:0];
        vspc_pkg::REG_DISPLAY_HEIGHT:    cfg.display_height    <= pwdata[9:0];
        vspc_pkg::REG_VERTICAL_OFFSET:   cfg.vertical_offset   <= pwdata[8:0];
        vspc_pkg::REG_HORIZONTAL_OFFSET: cfg.horizontal_offset <= pwdata[9:0];
        vspc_pkg::REG_SOURCE_X:          cfg.source_x          <= pwdata[9:0];
        vspc_pkg::REG_SOURCE_Y:          cfg.source_y          <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      vspc_pkg::REG_OUTPUT_FORMAT:     prdata = {31'd0, cfg.output_format};
      vspc_pkg::REG_TRUE_COLOR_ENABLE: prdata = {31'd0, cfg.true_color_enable};
      vspc_pkg::REG_CONTENT_WIDTH:     prdata = {21'd0, cfg.content_width};
      vspc_pkg::REG_DISPLAY_HEIGHT:    prdata = {22'd0, cfg.display_height};
      vspc_pkg::REG_VERTICAL_OFFSET:   prdata = {23'd0, cfg.vertical_offset};
      vspc_pkg::REG_HORIZONTAL_OFFSET: prdata = {22'd0, cfg.horizontal_offset};
      vspc_pkg::REG_SOURCE_X:          prdata = {22'd0, cfg.source_x};
      vspc_pkg::REG_SOURCE_Y:          prdata = {23'd0, cfg.source_y};
      default:                         prdata = '0;
    endcase
  end

endmodule

// File: src/vspc_region.sv
// ============================================================================
// vspc_region
// Three-stage position path: region classification and video-memory index.
// ============================================================================
module vspc_region (
  input  logic                              clk,
  input  vspc_pkg::cfg_t                    cfg,
  input  vspc_pkg::adv_t                    adv,
  input  logic [8:0]                        out_row,
  input  logic [10:0]                       out_col,
  output logic                              content_s2,
  output logic                              is_content,
  output logic [vspc_pkg::INDEX_W-1:0]      source_index
);

  localparam int YW = vspc_pkg::INDEX_W - vspc_pkg::ROW_BITS;

  logic [8:0]  top;
  logic [8:0]  r1;
  logic [10:0] c1;
  logic        row_lt1;
  logic        col_lt1;
  logic [9:0]  rows;
  logic [YW-1:0] yy;
  logic [vspc_pkg::INDEX_W-1:0] index2;
  logic        content2;
  logic [vspc_pkg::INDEX_W-1:0] index_s2;

  assign top = {1'b0, cfg.vertical_offset[8:1]};

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      row_lt1 <= out_row < top;
      r1      <= out_row - top;
      col_lt1 <= out_col < {1'b0, cfg.horizontal_offset};
      c1      <= out_col - {1'b0, cfg.horizontal_offset};
    end
  end

  always_comb begin
    rows     = (cfg.display_height > {1'b0, cfg.vertical_offset}) ?
               (cfg.display_height - {1'b0, cfg.vertical_offset}) : 10'd0;
    content2 = !row_lt1 && ({1'b0, r1} < rows) && !col_lt1 && (c1 < cfg.content_width);
    yy       = YW'(cfg.source_y + r1);
    index2   = {yy, {vspc_pkg::ROW_BITS{1'b0}}}
             + vspc_pkg::INDEX_W'(cfg.source_x)
             + vspc_pkg::INDEX_W'(c1);
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      content_s2 <= content2;
      index_s2   <= content2 ? index2 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      is_content   <= content_s2;
      source_index <= index_s2;
    end
  end

endmodule

// File: src/vspc_colour.sv
// ============================================================================
// vspc_colour
// Three-stage colour path: format conversion and shadow tolerance check.
// ============================================================================
module vspc_colour (
  input  logic           clk,
  input  vspc_pkg::cfg_t cfg,
  input  vspc_pkg::adv_t adv,
  input  logic [15:0]    vram_pixel,
  input  logic [23:0]    shadow_pixel,
  input  logic           content_s2,
  output logic [31:0]    pixel_value,
  output logic           shadow_write,
  output logic [23:0]    shadow_value
);

  logic [15:0] s1;
  logic [23:0] sh1;
  logic        mismatch;
  logic [23:0] wide;
  logic        mismatch2;
  logic [23:0] wide2;
  logic [23:0] xrgb2;
  logic [15:0] rgb2;
  logic [23:0] sh2;
  logic [31:0] pixel_value_next;
  logic        shadow_write_next;
  logic [23:0] shadow_value_next;

  function automatic logic far_apart(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] ea;
    logic [5:0] eb;
    ea = {1'b0, a};
    eb = {1'b0, b};
    return (ea > eb + 6'd1) || (eb > ea + 6'd1);
  endfunction

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1  <= vram_pixel;
      sh1 <= shadow_pixel;
    end
  end

  always_comb begin
    mismatch = far_apart(sh1[23:19], s1[4:0]) || far_apart(sh1[15:11], s1[9:5])
            || far_apart(sh1[7:3], s1[14:10]);
    wide     = {s1[4:0], s1[4:2], s1[9:5], s1[9:7], s1[14:10], s1[14:12]};
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      mismatch2 <= mismatch;
      wide2     <= wide;
      xrgb2     <= {s1[4:0], 3'd0, s1[9:5], 3'd0, s1[14:10], 3'd0};
      rgb2      <= {s1[4:0], s1[9:5], 1'b0, s1[14:10]};
      sh2       <= sh1;
    end
  end

  always_comb begin
    pixel_value_next  = '0;
    shadow_write_next = 1'b0;
    shadow_value_next = '0;
    if (content_s2) begin
      if (cfg.output_format) begin
        pixel_value_next = {16'd0, rgb2};
      end else if (cfg.true_color_enable) begin
        if (mismatch2) begin
          pixel_value_next  = {8'hFF, wide2};
          shadow_write_next = 1'b1;
          shadow_value_next = wide2;
        end else begin
          pixel_value_next = {8'hFF, sh2};
        end
      end else begin
        pixel_value_next = {8'hFF, xrgb2};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      pixel_value  <= pixel_value_next;
      shadow_write <= shadow_write_next;
      shadow_value <= shadow_value_next;
    end
  end

endmodule

// File: src/vram_scanout_pixel_converter_top.sv
// ============================================================================
// vram_scanout_pixel_converter_top
// Scan-out pixel converter with APB configuration and valid/ready channels.
// ============================================================================
// One result is delivered for every accepted position, and a new position is
// accepted in every cycle while the output is not stalled. There are three
// register stages: the first takes the region subtractions, the second the
// region compares and the index addition together with the colour checks,
// and the third is the output register. Configuration must only be written
// while the pipeline is empty.
module vram_scanout_pixel_converter_top (
  input  logic                        clk,
  input  logic                        rst,
  vspc_in_if.sink                     in_ch,
  vspc_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vspc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  vspc_pkg::cfg_t cfg;
  vspc_pkg::adv_t adv;
  logic           v1;
  logic           v2;
  logic           v3;
  logic           content_s2;

  assign adv.s3      = !v3 || out_ch.ready;
  assign adv.s2      = !v2 || adv.s3;
  assign adv.s1      = !v1 || adv.s2;
  assign in_ch.ready = adv.s1;
  assign out_ch.valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv.s1) v1 <= in_ch.valid;
      if (adv.s2) v2 <= v1;
      if (adv.s3) v3 <= v2;
    end
  end

  vspc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vspc_region u_region (
    .clk          (clk),
    .cfg          (cfg),
    .adv          (adv),
    .out_row      (in_ch.out_row),
    .out_col      (in_ch.out_col),
    .content_s2   (content_s2),
    .is_content   (out_ch.is_content),
    .source_index (out_ch.source_index)
  );

  vspc_colour u_colour (
    .clk          (clk),
    .cfg          (cfg),
    .adv          (adv),
    .vram_pixel   (in_ch.vram_pixel),
    .shadow_pixel (in_ch.shadow_pixel),
    .content_s2   (content_s2),
    .pixel_value  (out_ch.pixel_value),
    .shadow_write (out_ch.shadow_write),
    .shadow_value (out_ch.shadow_value)
  );

  // A shadow write-back only ever comes from a content pixel in XRGB8888 mode.
  a_write_in_content: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.shadow_write |-> out_ch.is_content && !cfg.output_format)
    else $error("shadow write outside content or in RGB565 mode");

  // Bars and margins carry an all-zero result.
  a_black_outside: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.is_content |->
      out_ch.pixel_value == '0 && out_ch.source_index == '0 && out_ch.shadow_value == '0)
    else $error("non-zero result outside content");

  // With the output stage empty the pipeline can always take a transaction.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output stage");

endmodule
